[src/jet_pkg.sv]
package jet_pkg;

   localparam int CfgAddrWidth = 4;

   typedef enum logic [1:0] {
      REG_MAX_ITER = 2'd0,
      REG_BAILOUT  = 2'd1,
      REG_CONST_RE = 2'd2,
      REG_CONST_IM = 2'd3
   } reg_index_type;

   localparam logic [15:0] MAX_ITER_RESET = 16'd256;
   localparam logic [31:0] BAILOUT_RESET  = 32'd1073741824;
   localparam logic [31:0] CONST_RE_RESET = 32'd161061274;
   localparam logic [31:0] CONST_IM_RESET = 32'd80530637;

   typedef struct packed {
      logic [15:0] max_iterations;
      logic [31:0] bailout;
      logic [31:0] const_re;
      logic [31:0] const_im;
   } cfg_type;

endpackage

[src/jet_csr.sv]
module jet_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [jet_pkg::CfgAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output jet_pkg::cfg_type                 cfg
);
   import jet_pkg::*;

   cfg_type cfg_ff;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iterations <= MAX_ITER_RESET;
         cfg_ff.bailout        <= BAILOUT_RESET;
         cfg_ff.const_re       <= CONST_RE_RESET;
         cfg_ff.const_im       <= CONST_IM_RESET;
      end else if (wr_en) begin
         case (reg_index_type'(csr_paddr[3:2]))
            REG_MAX_ITER: cfg_ff.max_iterations <= csr_pwdata[15:0];
            REG_BAILOUT:  cfg_ff.bailout <= csr_pwdata;
            REG_CONST_RE: cfg_ff.const_re <= csr_pwdata;
            REG_CONST_IM: cfg_ff.const_im <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[3:2]))
         REG_MAX_ITER: csr_prdata = {16'd0, cfg_ff.max_iterations};
         REG_BAILOUT:  csr_prdata = cfg_ff.bailout;
         REG_CONST_RE: csr_prdata = cfg_ff.const_re;
         REG_CONST_IM: csr_prdata = cfg_ff.const_im;
         default:      csr_prdata = '0;
      endcase
   end

endmodule

[src/jet_front.sv]
module jet_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_start_re,
   input  logic signed [COORD_WIDTH-1:0] req_start_im,
   input  logic                          pop,
   output logic                          q_valid,
   output logic signed [COORD_WIDTH-1:0] q_re,
   output logic signed [COORD_WIDTH-1:0] q_im
);
   // two-entry queue of starting points
   logic [1:0]                   valid_ff, valid_in;
   logic signed [COORD_WIDTH-1:0] re_ff [2];
   logic signed [COORD_WIDTH-1:0] im_ff [2];
   logic                         push;

   assign busy = valid_ff[1];
   assign push = start && !busy;
   assign q_valid = valid_ff[0];
   assign q_re = re_ff[0];
   assign q_im = im_ff[0];

   always_comb begin
      valid_in = valid_ff;
      if (pop) valid_in = {1'b0, valid_ff[1]};
      if (push) begin
         if (valid_in[0]) valid_in[1] = 1'b1;
         else valid_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (push && !(pop ? valid_ff[1] : valid_ff[0])) begin
         re_ff[0] <= req_start_re;
         im_ff[0] <= req_start_im;
      end else if (pop) begin
         re_ff[0] <= re_ff[1];
         im_ff[0] <= im_ff[1];
      end
      if (push && (pop ? valid_ff[1] : valid_ff[0])) begin
         re_ff[1] <= req_start_re;
         im_ff[1] <= req_start_im;
      end
   end

endmodule

[src/jet_core.sv]
module jet_core #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 28,
   parameter int ITER_WIDTH  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  jet_pkg::cfg_type              cfg,
   input  logic                          q_valid,
   input  logic signed [COORD_WIDTH-1:0] q_re,
   input  logic signed [COORD_WIDTH-1:0] q_im,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [ITER_WIDTH-1:0]         rsp_iterations
);
   import jet_pkg::*;

   localparam int PW = 2 * COORD_WIDTH;
   localparam int CW = 16;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_STEP
   } state_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   localparam coord_type CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   state_type         state_ff;
   coord_type         re_ff, im_ff;
   logic signed [PW-1:0] prr_ff, pii_ff, pri_ff;
   logic [CW-1:0]     count_ff;
   logic              first_ff;
   logic              lag_esc_ff;
   logic              rsp_valid_ff;
   logic [ITER_WIDTH-1:0] rsp_iter_ff;

   // shifted products, floor, one guard bit above the product width
   logic signed [PW:0] srr, sii, sri;
   coord_type         crr, cii, cri, nre, nim, dif;
   logic [PW:0]       wr, wi;
   logic [63:0]       wr64, wi64;
   logic [64:0]       mag;
   logic              escaped, limit;

   function automatic coord_type sat_c(input logic signed [PW:0] v);
      if (v > $signed({{(PW-COORD_WIDTH+1){1'b0}}, CMAX})) return CMAX;
      if (v < $signed({{(PW-COORD_WIDTH+1){1'b1}}, CMIN})) return CMIN;
      return v[COORD_WIDTH-1:0];
   endfunction

   function automatic coord_type sat_sum(input coord_type a, input coord_type b);
      logic signed [COORD_WIDTH:0] s;
      s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
      if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) return s[COORD_WIDTH] ? CMIN : CMAX;
      return s[COORD_WIDTH-1:0];
   endfunction

   function automatic coord_type sat_dif(input coord_type a, input coord_type b);
      logic signed [COORD_WIDTH:0] s;
      s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
      if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) return s[COORD_WIDTH] ? CMIN : CMAX;
      return s[COORD_WIDTH-1:0];
   endfunction

   always_comb begin
      srr = $signed({prr_ff[PW-1], prr_ff}) >>> FRAC_BITS;
      sii = $signed({pii_ff[PW-1], pii_ff}) >>> FRAC_BITS;
      sri = $signed({pri_ff[PW-1], pri_ff}) >>> (FRAC_BITS - 1);
      crr = sat_c(srr);
      cii = sat_c(sii);
      cri = sat_c(sri);
      dif = sat_dif(crr, cii);
      nre = sat_sum(dif, cfg.const_re);
      nim = sat_sum(cri, cfg.const_im);
      // squares are never negative
      wr = srr;
      wi = sii;
      wr64 = (PW + 1 > 64 && (wr >> 64) != 0) ? '1 : 64'(wr);
      wi64 = (PW + 1 > 64 && (wi >> 64) != 0) ? '1 : 64'(wi);
      mag = {1'b0, wr64} + {1'b0, wi64};
      escaped = !(mag[64] == 1'b0 && mag[63:0] < {32'd0, cfg.bailout});
      limit = !(count_ff < cfg.max_iterations);
   end

   assign pop = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_iterations = rsp_iter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  re_ff    <= q_re;
                  im_ff    <= q_im;
                  count_ff <= '0;
                  first_ff <= 1'b1;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prr_ff   <= re_ff * re_ff;
               pii_ff   <= im_ff * im_ff;
               pri_ff   <= re_ff * im_ff;
               state_ff <= S_STEP;
            end
            S_STEP: begin
               // test lags one step: first pass uses z0, later ones the previous point
               if ((first_ff ? escaped : lag_esc_ff) || limit) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_iter_ff  <= ITER_WIDTH'(count_ff);
                  state_ff     <= S_IDLE;
               end else if (first_ff) begin
                  first_ff   <= 1'b0;
                  lag_esc_ff <= escaped;
                  count_ff   <= count_ff + 1'b1;
                  re_ff      <= nre;
                  im_ff      <= nim;
                  state_ff   <= S_MUL;
               end else begin
                  lag_esc_ff <= escaped;
                  count_ff   <= count_ff + 1'b1;
                  re_ff      <= nre;
                  im_ff      <= nim;
                  state_ff   <= S_MUL;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[src/julia_escape_time.sv]
// Julia set escape-time counter.
// A starting point (req_start_re, req_start_im, signed Q3.28) is taken on a
// clock edge with start high and busy low. The block iterates z = z*z + c and
// returns the number of iterations in rsp_iterations with a one-cycle
// rsp_valid strobe; the receiver cannot stall, every result is simply taken.
// Each iteration passes through a multiply stage and an update stage; a new
// point is taken from the queue only once the previous one has finished.
// A two-word queue in front of the iteration engine lets up to two further
// points wait; busy is high while that queue is full.
// Registers on the APB port: 0x0 max_iterations, 0x4 bailout, 0x8 const_re,
// 0xC const_im. Write them only while the block is idle.
// Reset restores register defaults (256, 4.0, 0.6, 0.3) and empties the queue.
module julia_escape_time #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 28,
   parameter int ITER_WIDTH  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [COORD_WIDTH-1:0]    req_start_re,
   input  logic signed [COORD_WIDTH-1:0]    req_start_im,
   output logic                             rsp_valid,
   output logic [ITER_WIDTH-1:0]            rsp_iterations,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [jet_pkg::CfgAddrWidth-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import jet_pkg::*;

   cfg_type cfg;
   logic    pop, q_valid;
   logic signed [COORD_WIDTH-1:0] q_re, q_im;

   jet_csr u_csr (
      .clock, .reset,
      .csr_psel(psel), .csr_penable(penable), .csr_pwrite(pwrite),
      .csr_paddr(paddr), .csr_pwdata(pwdata), .csr_prdata(prdata),
      .csr_pready(pready), .cfg
   );

   jet_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock, .reset, .start, .busy, .req_start_re, .req_start_im,
      .pop, .q_valid, .q_re, .q_im
   );

   jet_core #(
      .COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .ITER_WIDTH(ITER_WIDTH)
   ) u_core (
      .clock, .reset, .cfg, .q_valid, .q_re, .q_im, .pop,
      .rsp_valid, .rsp_iterations
   );

endmodule

[src/jet_checker.sv]
module jet_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic pready
);
   ap_ready: assert property (@(posedge clock) pready)
      else $error("pready low");
   ap_rst_idle: assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("not idle after reset");
   ap_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   ap_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a new word");
endmodule

bind julia_escape_time jet_checker u_jet_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .pready
);
